// ===== rtl/psu_pkg.sv =====
`timescale 1ns / 1ps
package psu_pkg;

  localparam int unsigned MAX_ROW_BYTES = 8192;
  localparam int unsigned COL_W = $clog2(MAX_ROW_BYTES);
  localparam int unsigned LEN_W = 14;
  localparam int unsigned PIX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  localparam logic REG_ROW_LENGTH  = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  // One sample byte on its way from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [7:0]       kind;
    logic             first_row;
    logic             row_first;
    logic             last;
    logic [COL_W-1:0] col;
  } psu_item_t;

  function automatic logic [LEN_W-1:0] psu_eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(MAX_ROW_BYTES)) n = LEN_W'(MAX_ROW_BYTES);
    return n;
  endfunction

  // Byte offset of the left neighbour inside a window, newest byte at 0
  function automatic logic [1:0] psu_pix_idx(input logic [PIX_W-1:0] pix);
    logic [1:0] idx;
    if (pix == '0) idx = 2'd0;
    else if (pix > PIX_W'(4)) idx = 2'd3;
    else idx = 2'(pix - PIX_W'(1));
    return idx;
  endfunction

  function automatic logic [7:0] psu_paeth(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] r;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc) r = b;
    else r = c;
    return r;
  endfunction

endpackage

// ===== rtl/psu_ram.sv =====
`timescale 1ns / 1ps
module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/psu_front.sv =====
`timescale 1ns / 1ps
module psu_front import psu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_i,
  input  logic             image_start_i,
  input  logic [LEN_W-1:0] row_length_i,
  output logic             push_o,
  output psu_item_t        item_o
);

  logic             await_q, await_d;
  logic             first_row_q, first_row_d;
  logic [7:0]       kind_q, kind_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             is_filter;
  logic             last;
  logic [LEN_W-1:0] len;

  assign len       = psu_eff_len(row_length_i);
  assign is_filter = image_start_i | await_q;
  assign last      = ({1'b0, col_q} + LEN_W'(1)) >= len;

  always_comb begin
    await_d     = await_q;
    first_row_d = first_row_q;
    kind_d      = kind_q;
    col_d       = col_q;
    if (accept_i) begin
      if (is_filter) begin
        kind_d  = data_i;
        await_d = 1'b0;
        col_d   = '0;
        if (image_start_i) begin
          first_row_d = 1'b1;
        end
      end else if (last) begin
        await_d     = 1'b1;
        first_row_d = 1'b0;
        col_d       = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q     <= 1'b1;
      first_row_q <= 1'b1;
      kind_q      <= FILT_NONE;
      col_q       <= '0;
    end else begin
      await_q     <= await_d;
      first_row_q <= first_row_d;
      kind_q      <= kind_d;
      col_q       <= col_d;
    end
  end

  assign push_o           = accept_i & ~is_filter;
  assign item_o.data      = data_i;
  assign item_o.kind      = kind_q;
  assign item_o.first_row = first_row_q;
  assign item_o.row_first = (col_q == '0);
  assign item_o.last      = last;
  assign item_o.col       = col_q;

endmodule

// ===== rtl/psu_queue.sv =====
`timescale 1ns / 1ps
module psu_queue import psu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  psu_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output psu_item_t item_o
);

  psu_item_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

endmodule

// ===== rtl/psu_back.sv =====
`timescale 1ns / 1ps
module psu_back import psu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  psu_item_t        q_item_i,
  output logic             pop_o,
  input  logic [PIX_W-1:0] pixel_bytes_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  psu_item_t  b_item_q;
  logic       b_valid_q;
  logic       byp_q;
  logic [7:0] byp_data_q;
  logic [31:0] left_win_q, upleft_win_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic        b_adv;
  logic [7:0]  ram_rdata;
  logic [31:0] left_win, upleft_win;
  logic [1:0]  idx;
  logic [7:0]  a, b, c, pred, v;
  logic [8:0]  avg_sum;
  logic        byp_hit;

  assign b_adv = b_valid_q & (~out_valid_q | out_ready_i);
  assign pop_o = q_valid_i & (~b_valid_q | b_adv);

  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_prior_row (
    .clk_i  (clk_i),
    .we_i   (b_adv),
    .waddr_i(b_item_q.col),
    .wdata_i(v),
    .re_i   (pop_o),
    .raddr_i(q_item_i.col),
    .rdata_o(ram_rdata)
  );

  // The byte being written now is the one the entering item wants
  assign byp_hit = b_adv & pop_o & (b_item_q.col == q_item_i.col);

  assign left_win   = b_item_q.row_first ? '0 : left_win_q;
  assign upleft_win = b_item_q.row_first ? '0 : upleft_win_q;
  assign idx        = psu_pix_idx(pixel_bytes_i);
  assign a          = left_win[8*idx +: 8];
  assign b          = b_item_q.first_row ? 8'd0 : (byp_q ? byp_data_q : ram_rdata);
  assign c          = b_item_q.first_row ? 8'd0 : upleft_win[8*idx +: 8];
  assign avg_sum    = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (b_item_q.kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = psu_paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign v = b_item_q.data + pred;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q   <= q_item_i;
      byp_q      <= byp_hit;
      byp_data_q <= v;
    end
    if (b_adv) begin
      out_byte_q <= v;
      out_last_q <= b_item_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      left_win_q   <= '0;
      upleft_win_q <= '0;
    end else begin
      b_valid_q <= pop_o | (b_valid_q & ~b_adv);
      if (b_adv) begin
        out_valid_q  <= 1'b1;
        left_win_q   <= {left_win[23:0], v};
        upleft_win_q <= {upleft_win[23:0], b};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// PNG scanline reconstruction for 8-bit samples.
// s_axis carries the inflated stream one byte per transfer: tdata is the byte,
// tuser flags the filter byte of the first row of a new image. The first byte
// of every row selects the filter and gives no output; each following byte
// comes out on m_axis reconstructed, with tlast on the last byte of the row.
// Configure row_length (offset 0x0) and pixel_bytes (offset 0x4) over the APB
// port while the stream is idle.
// Throughput: one byte per cycle sustained while m_axis_tready is high, set by
// the single write and single read port of the prior-row memory (one access
// each per sample byte). Each sample is held in the queue, the back stage and
// the output register in turn. A queue of four entries sits between the
// classifying front and the reconstruction back; s_axis_tready falls only when
// that queue is full, so a stalled receiver backs up through the output
// register, the back stage and the queue before the input sees it.
// Reset clears all control state and the neighbour windows and waits for a
// filter byte of row 0; the prior-row memory is not cleared, and its read data
// is ignored for the first row, which writes it.
module png_scanline_unfilter import psu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0] s_axis_tuser,   // [0] image_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic [LEN_W-1:0] row_length_q;
  logic [PIX_W-1:0] pixel_bytes_q;
  logic             cfg_wr;
  logic             s_accept;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  psu_item_t        push_item;
  psu_item_t        q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= LEN_W'(1);
      pixel_bytes_q <= PIX_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_LENGTH:  row_length_q  <= pwdata[LEN_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes_q <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LENGTH:  prdata = 32'(row_length_q);
      REG_PIXEL_BYTES: prdata = 32'(pixel_bytes_q);
      default:         prdata = '0;
    endcase
  end

  assign s_axis_tready = ~q_full;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  psu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_accept),
    .data_i       (s_axis_tdata),
    .image_start_i(s_axis_tuser[0]),
    .row_length_i (row_length_q),
    .push_o       (push),
    .item_o       (push_item)
  );

  psu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  psu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .pop_o        (pop),
    .pixel_bytes_i(pixel_bytes_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("sample pushed into a full queue");

  a_start_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser[0]) |-> !push)
    else $error("image start byte pushed as a sample");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule
